### rtl/core/aad_pkg.sv
// Package for the area-average RGBA downscaler.
// Holds widths, limits, register indexes, the memory word, the command and
// status structs and the over-white blend. No dependencies.
package aad_pkg;

    localparam int MAX_DST_WIDTH = 1024;
    localparam int MAX_SRC_DIM   = 8192;

    localparam int ADDR_W  = $clog2(MAX_DST_WIDTH);
    localparam int DIM_W   = 14;
    localparam int DSTW_W  = 11;
    localparam int POS_W   = 13;
    localparam int SUM_W   = 35;
    localparam int CNT_W   = 27;
    localparam int NUM_W   = 27;
    localparam int PRD_W   = 28;
    localparam int QD_W    = 13;
    localparam int QM_W    = 8;
    localparam int STEP_W  = 4;
    localparam int CFG_W   = 14;
    localparam int IDX_W   = 2;

    localparam logic [IDX_W-1:0] CFG_SRC_WIDTH  = 2'd0;
    localparam logic [IDX_W-1:0] CFG_SRC_HEIGHT = 2'd1;
    localparam logic [IDX_W-1:0] CFG_DST_WIDTH  = 2'd2;
    localparam logic [IDX_W-1:0] CFG_DST_HEIGHT = 2'd3;

    typedef struct packed {
        logic [SUM_W-1:0] sum_r;
        logic [SUM_W-1:0] sum_g;
        logic [SUM_W-1:0] sum_b;
        logic [CNT_W-1:0] cnt;
    } t_acc;

    typedef struct packed {
        logic take;      // latch pixel, restart counters on frame start
        logic clr_en;    // write one zero word of the clearing sweep
        logic wrap;      // wrap position, blend pixel over white
        logic mul1;      // form block-index numerators, load divider
        logic div_step;  // one quotient bit of the block index
        logic mul2;      // block-end products, read the column's sums
        logic acc;       // accumulate, write back, advance position
        logic mean_step; // one quotient bit of the means
        logic out_load;  // load the output register
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic frame_start;
        logic emit;
    } t_stat;

    function automatic logic [7:0] over_white(input logic [7:0] c, input logic [7:0] a);
        logic [16:0] x;
        logic [16:0] t;
        begin
            x = 17'(c * a) + 17'(8'd255 * (8'd255 - a));
            t = x + (x >> 8) + 17'd1;
            over_white = t[15:8];
        end
    endfunction

endpackage

### rtl/core/area_average_downscaler_rgba_top.sv
// A pixel that closes no block is wrapped, divided and accumulated before ready returns;
// a closing pixel also runs the mean division and loads the output register, which waits
// while a result is held downstream, before the next pixel may transfer. The block-index
// divider has 13 steps, the mean divider 8. A pixel with frame start adds a sweep clearing
// all 1024 column sums. Reset (synchronous, active low) clears control, sets sizes to 1
// and runs the same sweep before the first pixel is taken; configuration writes go on meanwhile.
module area_average_downscaler_rgba_top import aad_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_W-1:0]  i_cfg_data,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic              i_frame_start,
    input  logic [7:0]        i_src_red,
    input  logic [7:0]        i_src_green,
    input  logic [7:0]        i_src_blue,
    input  logic [7:0]        i_src_alpha,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [ADDR_W-1:0] o_out_col,
    output logic [POS_W-1:0]  o_out_row_bottom_up,
    output logic [7:0]        o_out_blue,
    output logic [7:0]        o_out_green,
    output logic [7:0]        o_out_red,
    output logic              o_image_done
);

    // command and status between the sequencer and the datapath
    t_cmd  cmd;
    t_stat stat;

    // sequencer: one pixel at a time; the output register lets the next
    // pixel transfer while a result still waits downstream
    aad_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    // datapath: sizes, position, dividers, column sum memory, output register
    aad_dpath u_dpath (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_idx           (i_cfg_idx),
        .i_cfg_data          (i_cfg_data),
        .i_frame_start       (i_frame_start),
        .i_src_red           (i_src_red),
        .i_src_green         (i_src_green),
        .i_src_blue          (i_src_blue),
        .i_src_alpha         (i_src_alpha),
        .i_cmd               (cmd),
        .o_stat              (stat),
        .o_out_col           (o_out_col),
        .o_out_row_bottom_up (o_out_row_bottom_up),
        .o_out_blue          (o_out_blue),
        .o_out_green         (o_out_green),
        .o_out_red           (o_out_red),
        .o_image_done        (o_image_done)
    );

endmodule

### rtl/core/aad_ctrl.sv
// Controller of the area-average downscaler: sequences clearing, index
// division, accumulation, mean division and output transfer.
// Depends on aad_pkg.
module aad_ctrl import aad_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    output logic  o_valid,
    input  logic  i_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    typedef enum logic [8:0] {
        S_CLR  = 9'b000000001,
        S_IDLE = 9'b000000010,
        S_WRAP = 9'b000000100,
        S_MUL1 = 9'b000001000,
        S_DIV  = 9'b000010000,
        S_MUL2 = 9'b000100000,
        S_ACC  = 9'b001000000,
        S_MEAN = 9'b010000000,
        S_OUT  = 9'b100000000
    } t_state;

    t_state            r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;
    logic              r_pend, n_pend;
    logic              r_ovalid, n_ovalid;

    always_comb begin
        n_state  = r_state;
        n_step   = r_step;
        n_pend   = r_pend;
        o_cmd    = '0;
        n_ovalid = r_ovalid & ~i_ready;
        unique case (r_state)
            S_CLR: begin
                o_cmd.clr_en = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = r_pend ? S_WRAP : S_IDLE;
                    n_pend  = 1'b0;
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.take = 1'b1;
                    if (i_stat.frame_start) begin
                        n_state = S_CLR;
                        n_pend  = 1'b1;
                    end else begin
                        n_state = S_WRAP;
                    end
                end
            end
            S_WRAP: begin
                o_cmd.wrap = 1'b1;
                n_state    = S_MUL1;
            end
            S_MUL1: begin
                o_cmd.mul1 = 1'b1;
                n_step     = STEP_W'(QD_W - 1);
                n_state    = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_step         = r_step - 1'b1;
                if (r_step == '0) n_state = S_MUL2;
            end
            S_MUL2: begin
                o_cmd.mul2 = 1'b1;
                n_state    = S_ACC;
            end
            S_ACC: begin
                o_cmd.acc = 1'b1;
                n_step    = STEP_W'(QM_W - 1);
                n_state   = i_stat.emit ? S_MEAN : S_IDLE;
            end
            S_MEAN: begin
                o_cmd.mean_step = 1'b1;
                n_step          = r_step - 1'b1;
                if (r_step == '0) n_state = S_OUT;
            end
            S_OUT: begin
                // hold until the output register is free
                if (!r_ovalid || i_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_ovalid       = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_CLR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_step   <= '0;
            r_pend   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_step   <= n_step;
            r_pend   <= n_pend;
            r_ovalid <= n_ovalid;
        end
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_ovalid;

endmodule

### rtl/core/aad_dpath.sv
// Datapath of the area-average downscaler: size registers, position counters,
// shift-subtract dividers, per-column sum memory and output register.
// Depends on aad_pkg.
module aad_dpath import aad_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_W-1:0]  i_cfg_data,
    input  logic              i_frame_start,
    input  logic [7:0]        i_src_red,
    input  logic [7:0]        i_src_green,
    input  logic [7:0]        i_src_blue,
    input  logic [7:0]        i_src_alpha,
    input  t_cmd              i_cmd,
    output t_stat             o_stat,
    output logic [ADDR_W-1:0] o_out_col,
    output logic [POS_W-1:0]  o_out_row_bottom_up,
    output logic [7:0]        o_out_blue,
    output logic [7:0]        o_out_green,
    output logic [7:0]        o_out_red,
    output logic              o_image_done
);

    logic [DIM_W-1:0]  r_src_w, r_src_h, r_dst_h;
    logic [DSTW_W-1:0] r_dst_w;
    logic [DIM_W-1:0]  sw, sh, dh, dw_t;
    logic [DSTW_W-1:0] dw, dw_raw;

    logic [POS_W-1:0]  r_col, r_row;
    logic [7:0]        r_red, r_green, r_blue, r_alpha;
    logic [7:0]        r_ow_r, r_ow_g, r_ow_b;

    logic [NUM_W-1:0]  r_rem_x, r_rem_y, r_dsh_x, r_dsh_y;
    logic [QD_W-1:0]   r_q_x, r_q_y;
    logic [PRD_W-1:0]  r_cblk, r_cpos, r_rblk, r_rpos;

    t_acc              r_mem [MAX_DST_WIDTH];
    t_acc              r_rd, acc_new;
    logic [ADDR_W-1:0] r_clr_addr;

    logic [SUM_W-1:0]  r_mr, r_mg, r_mb, r_csh;
    logic [QM_W-1:0]   r_qr, r_qg, r_qb;

    logic [DIM_W-1:0]  col_p1, row_p1, row_t;
    logic              emit;

    // size clamps
    always_comb begin
        sw = (r_src_w == '0) ? DIM_W'(1) :
             (r_src_w > DIM_W'(MAX_SRC_DIM)) ? DIM_W'(MAX_SRC_DIM) : r_src_w;
        sh = (r_src_h == '0) ? DIM_W'(1) :
             (r_src_h > DIM_W'(MAX_SRC_DIM)) ? DIM_W'(MAX_SRC_DIM) : r_src_h;
        dh = (r_dst_h == '0) ? DIM_W'(1) : ((r_dst_h > sh) ? sh : r_dst_h);
        dw_raw = (r_dst_w == '0) ? DSTW_W'(1) : r_dst_w;
        dw_t = (DIM_W'(dw_raw) > sw) ? sw : DIM_W'(dw_raw);
        dw = (dw_t > DIM_W'(MAX_DST_WIDTH)) ? DSTW_W'(MAX_DST_WIDTH) : dw_t[DSTW_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_w <= DIM_W'(1);
            r_src_h <= DIM_W'(1);
            r_dst_w <= DSTW_W'(1);
            r_dst_h <= DIM_W'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SRC_WIDTH:  r_src_w <= i_cfg_data;
                CFG_SRC_HEIGHT: r_src_h <= i_cfg_data;
                CFG_DST_WIDTH:  r_dst_w <= i_cfg_data[DSTW_W-1:0];
                CFG_DST_HEIGHT: r_dst_h <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign col_p1 = {1'b0, r_col} + DIM_W'(1);
    assign row_p1 = {1'b0, r_row} + DIM_W'(1);
    assign row_t  = ({1'b0, r_col} >= sw) ? row_p1 : {1'b0, r_row};

    always_comb begin
        acc_new.sum_r = r_rd.sum_r + SUM_W'(r_ow_r);
        acc_new.sum_g = r_rd.sum_g + SUM_W'(r_ow_g);
        acc_new.sum_b = r_rd.sum_b + SUM_W'(r_ow_b);
        acc_new.cnt   = r_rd.cnt + CNT_W'(1);
    end

    // block closes when its right and bottom edges are reached
    assign emit = (r_cblk < r_cpos) && (r_rblk < r_rpos);

    assign o_stat.clr_last    = &r_clr_addr;
    assign o_stat.frame_start = i_frame_start;
    assign o_stat.emit        = emit;

    // position counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (i_cmd.take && i_frame_start) begin
            r_col <= '0;
            r_row <= '0;
        end else if (i_cmd.wrap) begin
            if ({1'b0, r_col} >= sw) r_col <= '0;
            r_row <= (row_t >= sh) ? '0 : row_t[POS_W-1:0];
        end else if (i_cmd.acc) begin
            if (col_p1 >= sw) begin
                r_col <= '0;
                r_row <= (row_p1 >= sh) ? '0 : row_p1[POS_W-1:0];
            end else begin
                r_col <= col_p1[POS_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clr_en) begin
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    // pixel, blend and block-index division
    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_red   <= i_src_red;
            r_green <= i_src_green;
            r_blue  <= i_src_blue;
            r_alpha <= i_src_alpha;
        end
        if (i_cmd.wrap) begin
            r_ow_r <= over_white(r_red, r_alpha);
            r_ow_g <= over_white(r_green, r_alpha);
            r_ow_b <= over_white(r_blue, r_alpha);
        end
        if (i_cmd.mul1) begin
            r_rem_x <= NUM_W'(col_p1) * NUM_W'(dw) - NUM_W'(1);
            r_rem_y <= NUM_W'(row_p1) * NUM_W'(dh) - NUM_W'(1);
            r_dsh_x <= NUM_W'(sw) << (QD_W - 1);
            r_dsh_y <= NUM_W'(sh) << (QD_W - 1);
            r_q_x   <= '0;
            r_q_y   <= '0;
        end else if (i_cmd.div_step) begin
            if (r_rem_x >= r_dsh_x) begin
                r_rem_x <= r_rem_x - r_dsh_x;
                r_q_x   <= {r_q_x[QD_W-2:0], 1'b1};
            end else begin
                r_q_x   <= {r_q_x[QD_W-2:0], 1'b0};
            end
            if (r_rem_y >= r_dsh_y) begin
                r_rem_y <= r_rem_y - r_dsh_y;
                r_q_y   <= {r_q_y[QD_W-2:0], 1'b1};
            end else begin
                r_q_y   <= {r_q_y[QD_W-2:0], 1'b0};
            end
            r_dsh_x <= r_dsh_x >> 1;
            r_dsh_y <= r_dsh_y >> 1;
        end
        if (i_cmd.mul2) begin
            r_cblk <= PRD_W'(r_q_x[DSTW_W-1:0] + DSTW_W'(1)) * PRD_W'(sw);
            r_cpos <= (PRD_W'(r_col) + PRD_W'(2)) * PRD_W'(dw);
            r_rblk <= (PRD_W'(r_q_y) + PRD_W'(1)) * PRD_W'(sh);
            r_rpos <= (PRD_W'(r_row) + PRD_W'(2)) * PRD_W'(dh);
        end
    end

    // per-column sum memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_en) begin
            r_mem[r_clr_addr] <= '0;
        end else if (i_cmd.acc) begin
            r_mem[r_q_x[ADDR_W-1:0]] <= emit ? '0 : acc_new;
        end
        if (i_cmd.mul2) begin
            r_rd <= r_mem[r_q_x[ADDR_W-1:0]];
        end
    end

    // means by shift-subtract, all three channels together
    always_ff @(posedge i_clk) begin
        if (i_cmd.acc) begin
            r_mr  <= acc_new.sum_r;
            r_mg  <= acc_new.sum_g;
            r_mb  <= acc_new.sum_b;
            r_csh <= SUM_W'(acc_new.cnt) << (QM_W - 1);
            r_qr  <= '0;
            r_qg  <= '0;
            r_qb  <= '0;
        end else if (i_cmd.mean_step) begin
            if (r_mr >= r_csh) begin
                r_mr <= r_mr - r_csh;
                r_qr <= {r_qr[QM_W-2:0], 1'b1};
            end else begin
                r_qr <= {r_qr[QM_W-2:0], 1'b0};
            end
            if (r_mg >= r_csh) begin
                r_mg <= r_mg - r_csh;
                r_qg <= {r_qg[QM_W-2:0], 1'b1};
            end else begin
                r_qg <= {r_qg[QM_W-2:0], 1'b0};
            end
            if (r_mb >= r_csh) begin
                r_mb <= r_mb - r_csh;
                r_qb <= {r_qb[QM_W-2:0], 1'b1};
            end else begin
                r_qb <= {r_qb[QM_W-2:0], 1'b0};
            end
            r_csh <= r_csh >> 1;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_out_col           <= r_q_x[ADDR_W-1:0];
            o_out_row_bottom_up <= POS_W'(dh - DIM_W'(1) - DIM_W'(r_q_y));
            o_out_blue          <= r_qb;
            o_out_green         <= r_qg;
            o_out_red           <= r_qr;
            o_image_done        <= (DIM_W'(r_q_x) == DIM_W'(dw) - DIM_W'(1)) &&
                                   (DIM_W'(r_q_y) == dh - DIM_W'(1));
        end
    end

endmodule

### rtl/core/aad_chk.sv
// Port-level checker for the area-average downscaler, bound to the top level.
// Depends on aad_pkg.
module aad_chk import aad_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_valid,
    input logic              o_ready,
    input logic              o_valid,
    input logic              i_ready,
    input logic [ADDR_W-1:0] o_out_col,
    input logic [POS_W-1:0]  o_out_row_bottom_up,
    input logic [7:0]        o_out_blue,
    input logic              o_image_done
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_out_col) && $stable(o_out_blue))
        else $error("result dropped or changed while stalled");

    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_ready)
        else $error("reset left a channel active");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("second pixel taken while one is in work");

    a_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_image_done |-> o_out_row_bottom_up == '0)
        else $error("image end flagged away from the bottom row");

endmodule

bind area_average_downscaler_rgba_top aad_chk u_aad_chk (
    .i_clk               (i_clk),
    .i_rst_n             (i_rst_n),
    .i_valid             (i_valid),
    .o_ready             (o_ready),
    .o_valid             (o_valid),
    .i_ready             (i_ready),
    .o_out_col           (o_out_col),
    .o_out_row_bottom_up (o_out_row_bottom_up),
    .o_out_blue          (o_out_blue),
    .o_image_done        (o_image_done)
);

### verif/tb.sv
// Testbench for area_average_downscaler_rgba_top: streams RGBA frames through
// the downscaler under several size settings and checks every output pixel.
// Depends on aad_pkg and the downscaler RTL only.
module tb import aad_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT_CYCLES = 1500000;
    localparam int SETTLE       = 40;     // margin once the block is idle

    typedef struct {
        bit [9:0]  col;
        bit [12:0] row;
        bit [7:0]  blue;
        bit [7:0]  green;
        bit [7:0]  red;
        bit        done;
    } t_block_mean;

    typedef struct {
        bit       fs;
        bit [7:0] r, g, b, a;
        bit       typed;        // expected value written out below
        bit [7:0] eb, eg, er;
    } t_pixel_row;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_cfg_we;
    logic [IDX_W-1:0]  i_cfg_idx;
    logic [CFG_W-1:0]  i_cfg_data;
    logic              i_valid;
    logic              o_ready;
    logic              i_frame_start;
    logic [7:0]        i_src_red, i_src_green, i_src_blue, i_src_alpha;
    logic              o_valid;
    logic              i_ready;
    logic [ADDR_W-1:0] o_out_col;
    logic [POS_W-1:0]  o_out_row_bottom_up;
    logic [7:0]        o_out_blue, o_out_green, o_out_red;
    logic              o_image_done;

    area_average_downscaler_rgba_top DUT (.*);

    // Predictor state: register copies and per-column block sums
    bit [13:0]       reg_sw, reg_sh, reg_dh;
    bit [10:0]       reg_dw;
    longint unsigned sum_r[1024], sum_g[1024], sum_b[1024], sum_n[1024];
    longint unsigned pos_col, pos_row;

    t_block_mean pending_means[$];
    int          errors;
    int          results_seen;
    int          pixels_sent;
    int          cycles;
    bit          idle_on;
    bit          hold_request;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Give up once the run exceeds the cycle limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic longint unsigned clamp_size(longint unsigned v, longint unsigned hi);
        if (v < 1) return 1;
        return (v > hi) ? hi : v;
    endfunction

    function automatic longint unsigned blend_white(longint unsigned c, longint unsigned a);
        return (c * a + 255 * (255 - a)) / 255;
    endfunction

    function automatic void clear_block_sums();
        for (int k = 0; k < 1024; k++) begin
            sum_r[k] = 0; sum_g[k] = 0; sum_b[k] = 0; sum_n[k] = 0;
        end
    endfunction

    // Advance the predictor by one pixel; return 1 when it closes a block
    function automatic bit predict_mean(input t_pixel_row px, output t_block_mean m);
        longint unsigned sw, sh, dw, dh, dx, dy, col_end, row_end, n;
        bit hit;
        sw = clamp_size(reg_sw, MAX_SRC_DIM);
        sh = clamp_size(reg_sh, MAX_SRC_DIM);
        dw = clamp_size(reg_dw, sw);
        dh = clamp_size(reg_dh, sh);
        hit = 1'b0;
        if (dw > MAX_DST_WIDTH) dw = MAX_DST_WIDTH;
        if (px.fs) begin
            pos_col = 0; pos_row = 0;
            clear_block_sums();
        end
        if (pos_col >= sw) begin pos_col = 0; pos_row++; end
        if (pos_row >= sh) pos_row = 0;
        dx = ((pos_col + 1) * dw - 1) / sw;
        dy = ((pos_row + 1) * dh - 1) / sh;
        if (dx >= dw) dx = dw - 1;
        if (dy >= dh) dy = dh - 1;
        col_end = (dx + 1) * sw / dw;
        row_end = (dy + 1) * sh / dh;
        sum_r[dx] += blend_white(px.r, px.a);
        sum_g[dx] += blend_white(px.g, px.a);
        sum_b[dx] += blend_white(px.b, px.a);
        sum_n[dx] += 1;
        if (pos_col + 1 >= col_end && pos_row + 1 >= row_end) begin
            n = sum_n[dx];
            m.col   = dx[9:0];
            m.row   = 13'(dh - 1 - dy);
            m.blue  = 8'(sum_b[dx] / n);
            m.green = 8'(sum_g[dx] / n);
            m.red   = 8'(sum_r[dx] / n);
            m.done  = (dx == dw - 1) && (dy == dh - 1);
            sum_r[dx] = 0; sum_g[dx] = 0; sum_b[dx] = 0; sum_n[dx] = 0;
            hit = 1'b1;
        end
        pos_col++;
        if (pos_col >= sw) begin
            pos_col = 0;
            pos_row++;
            if (pos_row >= sh) pos_row = 0;
        end
        return hit;
    endfunction

    // Offer one pixel, hold it until the transfer, then log its expectation
    task automatic send_pixel(input t_pixel_row px);
        t_block_mean m;
        if (idle_on && $urandom_range(0, 4) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_frame_start <= px.fs;
        i_src_red     <= px.r;
        i_src_green   <= px.g;
        i_src_blue    <= px.b;
        i_src_alpha   <= px.a;
        do @(posedge i_clk); while (!o_ready);
        pixels_sent++;
        if (predict_mean(px, m)) begin
            if (px.typed) begin
                m.blue = px.eb; m.green = px.eg; m.red = px.er;
            end
            pending_means.push_back(m);
        end
    endtask

    // Wait for every outstanding result and for the block to go idle
    task automatic drain();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending_means.size() > 0 || !o_ready);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_sizes(input bit [13:0] sw, sh, dw, dh);
        @(posedge i_clk);
        i_cfg_we <= 1'b1; i_cfg_idx <= CFG_SRC_WIDTH;  i_cfg_data <= sw;
        @(posedge i_clk);
        i_cfg_idx <= CFG_SRC_HEIGHT; i_cfg_data <= sh;
        @(posedge i_clk);
        i_cfg_idx <= CFG_DST_WIDTH;  i_cfg_data <= dw;
        @(posedge i_clk);
        i_cfg_idx <= CFG_DST_HEIGHT; i_cfg_data <= dh;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        reg_sw = sw; reg_sh = sh; reg_dw = dw[10:0]; reg_dh = dh;
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: mismatch on %s: expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endtask

    // Output side: check each transfer, then pick ready for the next edge
    initial begin : result_side
        int stall_left;
        int hold_left;
        t_block_mean want;
        stall_left = 0;
        hold_left  = 0;
        forever begin
            @(posedge i_clk);
            if (o_valid && i_ready) begin
                results_seen++;
                if (pending_means.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual col %0d row %0d",
                             $time, o_out_col, o_out_row_bottom_up);
                    errors++;
                end else begin
                    want = pending_means.pop_front();
                    check_field("out_col", want.col, o_out_col);
                    check_field("out_row_bottom_up", want.row, o_out_row_bottom_up);
                    check_field("out_blue", want.blue, o_out_blue);
                    check_field("out_green", want.green, o_out_green);
                    check_field("out_red", want.red, o_out_red);
                    check_field("image_done", want.done, o_image_done);
                end
            end
            // long enough to outlast the clearing sweep and back the block up
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = 2000;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                i_ready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 7) - 1;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // Directed rows run at the reset sizes, so each pixel is its own block
    t_pixel_row directed[9] = '{
        '{1, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1, 8'hFF, 8'hFF, 8'hFF},
        '{0, 8'h00, 8'h00, 8'h00, 8'hFF, 1, 8'h00, 8'h00, 8'h00},
        '{0, 8'h00, 8'h00, 8'h00, 8'h00, 1, 8'hFF, 8'hFF, 8'hFF},
        '{0, 8'hA5, 8'h5A, 8'h3C, 8'h00, 1, 8'hFF, 8'hFF, 8'hFF},
        '{0, 8'h12, 8'h34, 8'h56, 8'hFF, 1, 8'h56, 8'h34, 8'h12},
        '{0, 8'hFF, 8'h00, 8'h80, 8'h80, 0, 0, 0, 0},
        '{0, 8'h01, 8'h02, 8'h03, 8'h01, 0, 0, 0, 0},
        '{1, 8'h7F, 8'h80, 8'hFE, 8'hFE, 0, 0, 0, 0},
        '{0, 8'hAA, 8'h55, 8'hCC, 8'h33, 0, 0, 0, 0}
    };

    initial begin : stimulus
        t_pixel_row px;
        int sw, sh, dw, dh, frame_px, phase;
        errors = 0; results_seen = 0; pixels_sent = 0; cycles = 0;
        idle_on = 1'b1; hold_request = 1'b0;
        i_rst_n = 1'b0; i_cfg_we = 1'b0; i_cfg_idx = CFG_SRC_WIDTH; i_cfg_data = '0;
        i_valid = 1'b0; i_frame_start = 1'b0; i_ready = 1'b0;
        i_src_red = '0; i_src_green = '0; i_src_blue = '0; i_src_alpha = '0;
        reg_sw = 1; reg_sh = 1; reg_dw = 1; reg_dh = 1;
        pos_col = 0; pos_row = 0;
        clear_block_sums();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed[k]) send_pixel(directed[k]);

        // Hold the output off with one result per pixel so the block backs up
        drain();
        write_sizes(14'd1, 14'd16383, 14'd1, 14'd16383);
        hold_request = 1'b1;
        for (int k = 0; k < 40; k++) begin
            px = '{k == 0, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 0, 0, 0, 0};
            send_pixel(px);
        end

        phase = 0;
        while (pixels_sent < 1250) begin
            drain();
            case (phase)
                0: begin sw = 0;     sh = 0; dw = 0;    dh = 0; end
                1: begin sw = 16383; sh = 0; dw = 2047; dh = 0; end
                2: begin sw = 8192;  sh = 2; dw = 1024; dh = 2; end
                3: begin sw = 5;     sh = 3; dw = 9;    dh = 7; end
                default: begin
                    sw = $urandom_range(1, 12);
                    sh = $urandom_range(1, 12);
                    dw = $urandom_range(0, sw + 2);
                    dh = $urandom_range(0, sh + 2);
                end
            endcase
            write_sizes(14'(sw), 14'(sh), 14'(dw), 14'(dh));
            if (pixels_sent > 1050) idle_on = 1'b0;
            // Wide phases get a short strip; small ones a few whole frames
            frame_px = (sw > 100) ? 48 :
                       int'(clamp_size(sw, MAX_SRC_DIM) * clamp_size(sh, MAX_SRC_DIM));
            for (int f = 0; f < ((sw > 100) ? 1 : $urandom_range(1, 4)); f++) begin
                for (int k = 0; k < frame_px + $urandom_range(0, 2); k++) begin
                    px.fs = (k == 0) ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 60) == 0);
                    px.r = 8'($urandom); px.g = 8'($urandom);
                    px.b = 8'($urandom);
                    case ($urandom_range(0, 3))
                        0: px.a = 8'hFF;
                        1: px.a = 8'h00;
                        default: px.a = 8'($urandom);
                    endcase
                    px.typed = 1'b0;
                    send_pixel(px);
                end
            end
            phase++;
        end

        drain();
        $display("Sent %0d pixels over %0d size settings, checked %0d block means.",
                 pixels_sent, phase + 2, results_seen);
        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

### area_average_downscaler_rgba_top.f
rtl/core/aad_pkg.sv
rtl/core/aad_ctrl.sv
rtl/core/aad_dpath.sv
rtl/core/area_average_downscaler_rgba_top.sv
rtl/core/aad_chk.sv
verif/tb.sv
